// ===== rtl/core/tpsd_pkg.sv =====
package tpsd_pkg;

   localparam int IDX_W = 12;
   localparam int CNT_W = 7;
   localparam int WGT_W = 11;
   localparam int CSR_W = 16;
   localparam int CSR_IDX_W = 3;

   localparam logic [7:0]  TCP_PROTO  = 8'd6;
   localparam int          ACK_BIT    = 4;
   localparam logic [15:0] PRIV_LIMIT = 16'd1024;
   localparam logic [WGT_W-1:0] WEIGHT_MAX = 11'd2047;

   localparam logic [3:0]  RST_WEIGHT_PRIV = 4'd3;
   localparam logic [3:0]  RST_WEIGHT_REG  = 4'd1;
   localparam logic [9:0]  RST_THRESHOLD   = 10'd21;
   localparam logic [15:0] RST_STALE       = 16'd3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WEIGHT_PRIV = 3'd0,
      CSR_WEIGHT_REG  = 3'd1,
      CSR_THRESHOLD   = 3'd2,
      CSR_STALE       = 3'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_NOT_TCP  = 3'd0,
      ST_ACK_SKIP = 3'd1,
      ST_FULL     = 3'd2,
      ST_REPEAT   = 3'd3,
      ST_NEW_PORT = 3'd4,
      ST_ALERT    = 3'd5
   } status_type;

   typedef struct packed {
      logic              valid;
      logic              found;
      logic              port_hit;
      logic [IDX_W-1:0]  idx;
      logic [WGT_W-1:0]  weight;
      logic [CNT_W-1:0]  count;
      logic [31:0]       first;
      logic [7:0]        flags_or;
      logic [7:0]        flags_and;
      logic              old_any;
      logic [31:0]       old_time;
      logic [IDX_W-1:0]  old_idx;
   } token_type;

   typedef struct packed {
      logic              en;
      logic              init;
      logic              store;
      logic [IDX_W-1:0]  idx;
      logic [CNT_W-1:0]  pos;
      logic [CNT_W-1:0]  count;
      logic [WGT_W-1:0]  weight;
      logic [7:0]        flags_or;
      logic [7:0]        flags_and;
      logic [31:0]       addr;
      logic [31:0]       now;
      logic [15:0]       port;
   } wr_type;

endpackage

// ===== rtl/core/tpsd_ifs.sv =====
interface tpsd_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  protocol;
   logic [31:0] src_addr;
   logic [15:0] dst_port;
   logic [7:0]  flag_bits;
   logic [31:0] timestamp;

   modport source (output valid, protocol, src_addr, dst_port, flag_bits, timestamp,
                   input ready);
   modport sink (input valid, protocol, src_addr, dst_port, flag_bits, timestamp,
                 output ready);
endinterface

interface tpsd_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [31:0] host_addr;
   logic [4:0]  ports_listed;
   logic [10:0] weight_sum;
   logic [31:0] created_at;
   logic [31:0] duration;
   logic [7:0]  flags_union;
   logic [7:0]  flags_common;

   modport source (output valid, status, host_addr, ports_listed, weight_sum, created_at,
                   duration, flags_union, flags_common, input ready);
   modport sink (input valid, status, host_addr, ports_listed, weight_sum, created_at,
                 duration, flags_union, flags_common, output ready);
endinterface

// ===== rtl/core/tpsd_cell.sv =====
module tpsd_cell #(
   parameter int INDEX = 0,
   parameter int PORTS_PER_HOST = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [31:0]          src_addr,
   input  logic [15:0]          dst_port,
   input  tpsd_pkg::token_type  tok_in,
   output tpsd_pkg::token_type  tok_out,
   input  tpsd_pkg::wr_type     wr
);
   localparam int CW = $clog2(PORTS_PER_HOST + 1);
   localparam int IW = (PORTS_PER_HOST > 1) ? $clog2(PORTS_PER_HOST) : 1;

   logic                    valid_ff;
   logic [31:0]             addr_ff;
   logic [31:0]             last_ff;
   logic [31:0]             first_ff;
   logic [CW-1:0]           count_ff;
   logic [tpsd_pkg::WGT_W-1:0] weight_ff;
   logic [7:0]              for_ff;
   logic [7:0]              fand_ff;
   logic [15:0]             ports_ff [PORTS_PER_HOST];
   tpsd_pkg::token_type     tok_ff;
   tpsd_pkg::token_type     tok_in_next;
   logic                    hit;
   logic                    sel;

   assign sel = wr.en && (wr.idx == tpsd_pkg::IDX_W'(INDEX));

   always_comb begin
      hit = 1'b0;
      for (int j = 0; j < PORTS_PER_HOST; j++) begin
         if ((CW'(j) < count_ff) && (ports_ff[j] == dst_port)) begin
            hit = 1'b1;
         end
      end
   end

   always_comb begin
      tok_in_next = tok_in;
      if (!tok_in.found && valid_ff && (addr_ff == src_addr)) begin
         tok_in_next.found     = 1'b1;
         tok_in_next.port_hit  = hit;
         tok_in_next.idx       = tpsd_pkg::IDX_W'(INDEX);
         tok_in_next.weight    = weight_ff;
         tok_in_next.count     = tpsd_pkg::CNT_W'(count_ff);
         tok_in_next.first     = first_ff;
         tok_in_next.flags_or  = for_ff;
         tok_in_next.flags_and = fand_ff;
      end
      if (valid_ff && (!tok_in.old_any || (last_ff < tok_in.old_time))) begin
         tok_in_next.old_any  = 1'b1;
         tok_in_next.old_time = last_ff;
         tok_in_next.old_idx  = tpsd_pkg::IDX_W'(INDEX);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_next;
         if (sel) begin
            valid_ff <= 1'b1;
         end
      end
      if (sel) begin
         if (wr.init) begin
            addr_ff  <= wr.addr;
            first_ff <= wr.now;
         end
         last_ff   <= wr.now;
         count_ff  <= CW'(wr.count);
         weight_ff <= wr.weight;
         for_ff    <= wr.flags_or;
         fand_ff   <= wr.flags_and;
         if (wr.store) begin
            ports_ff[wr.pos[IW-1:0]] <= wr.port;
         end
      end
   end

   assign tok_out = tok_ff;

endmodule

// ===== rtl/core/tcp_port_scan_detector_core.sv =====
// Weighted TCP port scan detector.
// req_bus carries one parsed packet header per transfer; rsp_bus returns exactly
// one result per header, in order. csr_we/csr_index/csr_wdata write the weights,
// the alert threshold and the stale time; write them only while the block is idle.
// Host entries live in a row of HOST_ENTRIES cells. A lookup token walks the row,
// one cell per cycle, collecting the matching entry and the oldest entry.
// A TCP packet without ACK passes the row walk, the pick and the update before
// its result is given; an ignored packet skips the row walk and the pick.
// One header is in work at a time: the block takes no new header until the last
// one has left the update step.
// A new header is taken while a finished result still waits in the output
// register; if the receiver stalls, the next result holds in the update step.
// Reset clears the entry valid bits and the active count and sets the CSR
// registers to their defaults; no clearing pass is needed.
module tcp_port_scan_detector_core #(
   parameter int HOST_ENTRIES = 256,
   parameter int PORTS_PER_HOST = 20
) (
   input  logic                               clock,
   input  logic                               reset,
   tpsd_req_if.sink                           req_bus,
   tpsd_rsp_if.source                         rsp_bus,
   input  logic                               csr_we,
   input  logic [tpsd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tpsd_pkg::CSR_W-1:0]         csr_wdata
);
   localparam int AW = $clog2(HOST_ENTRIES + 1);

   typedef enum logic [1:0] {S_IDLE, S_SCAN, S_APPLY} state_type;

   typedef struct packed {
      logic                       ok;
      logic                       init;
      logic                       hit;
      logic [tpsd_pkg::IDX_W-1:0] idx;
      logic [tpsd_pkg::WGT_W-1:0] weight;
      logic [tpsd_pkg::CNT_W-1:0] count;
      logic [31:0]                first;
      logic [7:0]                 flags_or;
      logic [7:0]                 flags_and;
   } pick_type;

   state_type            state_ff;
   logic [3:0]           wpriv_ff;
   logic [3:0]           wreg_ff;
   logic [9:0]           thr_ff;
   logic [15:0]          stale_ff;
   logic [AW-1:0]        active_ff;
   logic                 ignore_ff;
   tpsd_pkg::status_type ign_status_ff;
   logic [31:0]          src_ff;
   logic [15:0]          port_ff;
   logic [7:0]           flags_ff;
   logic [31:0]          now_ff;
   logic                 start_ff;
   pick_type             pick_ff;
   pick_type             pick_in;
   logic                 append_in;
   tpsd_pkg::wr_type     wr_ff;
   tpsd_pkg::wr_type     wr_in;
   tpsd_pkg::token_type  tok_head;
   tpsd_pkg::token_type  tok [HOST_ENTRIES + 1];
   tpsd_pkg::token_type  fin;
   logic                 stale;
   logic [31:0]          age;
   logic [11:0]          sum_wide;
   logic [tpsd_pkg::WGT_W-1:0] sum;
   logic                 alert;
   logic [tpsd_pkg::CNT_W-1:0] cnt_new;
   tpsd_pkg::status_type status_in;
   logic                 out_free;

   logic                 rsp_valid_ff;
   tpsd_pkg::status_type rsp_status_ff;
   logic [31:0]          rsp_addr_ff;
   logic [4:0]           rsp_ports_ff;
   logic [10:0]          rsp_sum_ff;
   logic [31:0]          rsp_first_ff;
   logic [31:0]          rsp_dur_ff;
   logic [7:0]           rsp_or_ff;
   logic [7:0]           rsp_and_ff;

   always_comb begin
      tok_head       = '0;
      tok_head.valid = start_ff;
   end

   assign tok[0] = tok_head;

   for (genvar g = 0; g < HOST_ENTRIES; g++) begin : g_cell
      tpsd_cell #(.INDEX(g), .PORTS_PER_HOST(PORTS_PER_HOST)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .src_addr  (src_ff),
         .dst_port  (port_ff),
         .tok_in    (tok[g]),
         .tok_out   (tok[g+1]),
         .wr        (wr_ff)
      );
   end

   assign fin = tok[HOST_ENTRIES];
   assign age = now_ff - fin.old_time;
   assign stale = fin.old_any && (now_ff >= fin.old_time) && (age > {16'd0, stale_ff});

   always_comb begin
      pick_in           = '0;
      append_in         = 1'b0;
      pick_in.flags_and = 8'hFF;
      pick_in.first     = now_ff;
      if (fin.found) begin
         pick_in.ok        = 1'b1;
         pick_in.hit       = fin.port_hit;
         pick_in.idx       = fin.idx;
         pick_in.weight    = fin.weight;
         pick_in.count     = fin.count;
         pick_in.first     = fin.first;
         pick_in.flags_or  = fin.flags_or;
         pick_in.flags_and = fin.flags_and;
      end else if (stale) begin
         pick_in.ok   = 1'b1;
         pick_in.init = 1'b1;
         pick_in.idx  = fin.old_idx;
      end else if (active_ff < AW'(HOST_ENTRIES)) begin
         pick_in.ok   = 1'b1;
         pick_in.init = 1'b1;
         pick_in.idx  = tpsd_pkg::IDX_W'(active_ff);
         append_in    = 1'b1;
      end
   end

   always_comb begin
      sum_wide = 12'(pick_ff.weight) +
                 ((port_ff < tpsd_pkg::PRIV_LIMIT) ? 12'(wpriv_ff) : 12'(wreg_ff));
      sum   = pick_ff.hit ? pick_ff.weight :
              (sum_wide > 12'(tpsd_pkg::WEIGHT_MAX)) ? tpsd_pkg::WEIGHT_MAX : sum_wide[10:0];
      alert = !pick_ff.hit && ({1'b0, sum} >= 12'(thr_ff));
      cnt_new = (!pick_ff.hit && (pick_ff.count < tpsd_pkg::CNT_W'(PORTS_PER_HOST))) ?
                pick_ff.count + 1'b1 : pick_ff.count;
      status_in = pick_ff.hit ? tpsd_pkg::ST_REPEAT :
                  alert ? tpsd_pkg::ST_ALERT : tpsd_pkg::ST_NEW_PORT;
      wr_in           = '0;
      wr_in.en        = pick_ff.ok;
      wr_in.init      = pick_ff.init;
      wr_in.store     = cnt_new != pick_ff.count;
      wr_in.idx       = pick_ff.idx;
      wr_in.pos       = pick_ff.count;
      wr_in.count     = cnt_new;
      wr_in.weight    = alert ? '0 : sum;
      wr_in.flags_or  = pick_ff.flags_or | flags_ff;
      wr_in.flags_and = pick_ff.flags_and & flags_ff;
      wr_in.addr      = src_ff;
      wr_in.now       = now_ff;
      wr_in.port      = port_ff;
   end

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wpriv_ff     <= tpsd_pkg::RST_WEIGHT_PRIV;
         wreg_ff      <= tpsd_pkg::RST_WEIGHT_REG;
         thr_ff       <= tpsd_pkg::RST_THRESHOLD;
         stale_ff     <= tpsd_pkg::RST_STALE;
         active_ff    <= '0;
         start_ff     <= 1'b0;
         wr_ff.en     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         start_ff <= 1'b0;
         wr_ff.en <= 1'b0;
         if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               tpsd_pkg::CSR_WEIGHT_PRIV: wpriv_ff <= csr_wdata[3:0];
               tpsd_pkg::CSR_WEIGHT_REG:  wreg_ff  <= csr_wdata[3:0];
               tpsd_pkg::CSR_THRESHOLD:   thr_ff   <= csr_wdata[9:0];
               tpsd_pkg::CSR_STALE:       stale_ff <= csr_wdata[15:0];
               default: ;
            endcase
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_bus.valid) begin
                  src_ff   <= req_bus.src_addr;
                  port_ff  <= req_bus.dst_port;
                  flags_ff <= req_bus.flag_bits;
                  now_ff   <= req_bus.timestamp;
                  if (req_bus.protocol != tpsd_pkg::TCP_PROTO) begin
                     ignore_ff     <= 1'b1;
                     ign_status_ff <= tpsd_pkg::ST_NOT_TCP;
                     state_ff      <= S_APPLY;
                  end else if (req_bus.flag_bits[tpsd_pkg::ACK_BIT]) begin
                     ignore_ff     <= 1'b1;
                     ign_status_ff <= tpsd_pkg::ST_ACK_SKIP;
                     state_ff      <= S_APPLY;
                  end else begin
                     ignore_ff <= 1'b0;
                     start_ff  <= 1'b1;
                     state_ff  <= S_SCAN;
                  end
               end
            end
            S_SCAN: begin
               if (fin.valid) begin
                  pick_ff <= pick_in;
                  if (append_in) begin
                     active_ff <= active_ff + 1'b1;
                  end
                  if (!pick_in.ok) begin
                     ignore_ff     <= 1'b1;
                     ign_status_ff <= tpsd_pkg::ST_FULL;
                  end
                  state_ff <= S_APPLY;
               end
            end
            S_APPLY: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
                  if (ignore_ff) begin
                     rsp_status_ff <= ign_status_ff;
                     rsp_addr_ff   <= '0;
                     rsp_ports_ff  <= '0;
                     rsp_sum_ff    <= '0;
                     rsp_first_ff  <= '0;
                     rsp_dur_ff    <= '0;
                     rsp_or_ff     <= '0;
                     rsp_and_ff    <= '0;
                  end else begin
                     wr_ff         <= wr_in;
                     rsp_status_ff <= status_in;
                     rsp_addr_ff   <= src_ff;
                     rsp_ports_ff  <= cnt_new[4:0];
                     rsp_sum_ff    <= sum;
                     rsp_first_ff  <= pick_ff.first;
                     rsp_dur_ff    <= now_ff - pick_ff.first;
                     rsp_or_ff     <= wr_in.flags_or;
                     rsp_and_ff    <= wr_in.flags_and;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.status       = rsp_status_ff;
   assign rsp_bus.host_addr    = rsp_addr_ff;
   assign rsp_bus.ports_listed = rsp_ports_ff;
   assign rsp_bus.weight_sum   = rsp_sum_ff;
   assign rsp_bus.created_at   = rsp_first_ff;
   assign rsp_bus.duration     = rsp_dur_ff;
   assign rsp_bus.flags_union  = rsp_or_ff;
   assign rsp_bus.flags_common = rsp_and_ff;

endmodule
